// ----- sv/stereo_equal_power_panner_assert.svh -----
// assertion macros for the stereo panner, clocked on clk and disabled in reset
// used by the top level only; define NO_ASSERTIONS to drop them
`ifndef STEREO_EQUAL_POWER_PANNER_ASSERT_SVH
`define STEREO_EQUAL_POWER_PANNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition must never hold
`define SEPP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define SEPP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SEPP_ASSERT_NEVER(lbl, cond, msg)
`define SEPP_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/sepp_pkg.sv -----
// shared types and constants for the stereo equal-power panner
// no dependencies
package sepp_pkg;

  // one in Q1.15
  localparam int UNIT_Q15 = 32768;

  // pi/2 in Q2.30 for the sine table build
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // taylor series divisors (2n)(2n+1), n = 1..12
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

  // pan scale after reset, 1.0 in Q2.14
  localparam logic [15:0] PAN_SCALE_RESET = 16'd16384;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  typedef enum logic {
    REG_FLIP_MODE = 1'b0,
    REG_PAN_SCALE = 1'b1
  } reg_idx_t;

  // configuration seen by the front
  typedef struct packed {
    logic        flip_mode;
    logic [15:0] pan_scale;
  } cfg_t;

  // queue status
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

endpackage

// ----- sv/sepp_front.sv -----
// front of the panner: scales, clamps and flips the pan, classifies the side
// and computes the sine table index; depends on sepp_pkg
module sepp_front #(
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sepp_pkg::cfg_t                cfg,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic signed [15:0]            in_pan,
  output logic                          push,
  output logic [SAMPLE_BITS-1:0]        push_left,
  output logic [SAMPLE_BITS-1:0]        push_right,
  output logic [IDX_W-1:0]              push_idx,
  output logic                          push_pos,
  output logic [1:0]                    inflight
);
  import sepp_pkg::*;

  localparam logic signed [31:0] CLAMP_HI = 32'sd32768;
  localparam logic signed [31:0] CLAMP_LO = -32'sd32768;
  localparam logic [16:0]        IDX_MAX  = 17'(SINE_TABLE_DEPTH);

  // stage 1: pan times scale
  logic                          v1_r;
  logic [SAMPLE_BITS-1:0]        l1_r, r1_r;
  logic signed [31:0]            prod1_r;
  logic signed [32:0]            prod_full;

  assign prod_full = $signed(in_pan) * $signed({1'b0, cfg.pan_scale});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    l1_r    <= in_left;
    r1_r    <= in_right;
    prod1_r <= prod_full[31:0];
  end

  // stage 2: truncate toward zero, clamp, flip, fold into phase
  logic signed [31:0] quot;
  logic signed [16:0] p_clamp, p_flip;
  logic               pos;
  logic [15:0]        phase;

  always_comb begin
    if (prod1_r[31]) begin
      quot = (prod1_r + 32'sd16383) >>> 14;
    end else begin
      quot = prod1_r >>> 14;
    end
    priority if (quot > CLAMP_HI) begin
      p_clamp = 17'sd32768;
    end else if (quot < CLAMP_LO) begin
      p_clamp = -17'sd32768;
    end else begin
      p_clamp = quot[16:0];
    end
    p_flip = cfg.flip_mode ? -p_clamp : p_clamp;
    pos    = (p_flip > 17'sd0);
    phase  = pos ? p_flip[15:0] : 16'(p_flip + 17'sd32768);
  end

  logic                   v2_r;
  logic [SAMPLE_BITS-1:0] l2_r, r2_r;
  logic [15:0]            phase2_r;
  logic                   pos2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    l2_r     <= l1_r;
    r2_r     <= r1_r;
    phase2_r <= phase;
    pos2_r   <= pos;
  end

  // nearest table entry for the phase
  logic [31:0] idx_scaled;
  logic [16:0] idx_full;

  always_comb begin
    idx_scaled = 32'(phase2_r) * 32'(SINE_TABLE_DEPTH) + 32'd16384;
    idx_full   = idx_scaled[31:15];
    if (idx_full > IDX_MAX) begin
      idx_full = IDX_MAX;
    end
  end

  assign push       = v2_r;
  assign push_left  = l2_r;
  assign push_right = r2_r;
  assign push_idx   = idx_full[IDX_W-1:0];
  assign push_pos   = pos2_r;
  assign inflight   = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

// ----- sv/sepp_queue.sv -----
// short queue between front and back of the panner, registered read
// depends on sepp_pkg for depth and status type
module sepp_queue #(
  parameter int W = 42
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [W-1:0]          wdata,
  input  logic                  pop,
  output logic                  rvalid,
  output logic [W-1:0]          rdata,
  output sepp_pkg::queue_stat_t stat
);
  import sepp_pkg::*;

  logic [W-1:0]      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              rvalid_r;
  logic [W-1:0]      rdata_r;
  logic              do_pop;

  assign do_pop = pop && (count_r != '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      rptr_r   <= '0;
      count_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      count_r  <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
      rvalid_r <= do_pop;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
    if (do_pop) begin
      rdata_r <= mem[rptr_r];
    end
  end

  assign rvalid     = rvalid_r;
  assign rdata      = rdata_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.count = count_r;

endmodule

// ----- sv/sepp_back.sv -----
// back of the panner: quarter-sine lookup, gain multiply, round and saturate
// depends on sepp_pkg for table build constants
module sepp_back #(
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic [IDX_W-1:0]              in_idx,
  input  logic                          in_pos,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);
  import sepp_pkg::*;

  localparam int PW = SAMPLE_BITS + 17;
  localparam int SW = SAMPLE_BITS + 18;
  localparam logic [IDX_W-1:0]     IDX_TOP = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic signed [SW-1:0] SAT_HI  = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO  = SW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [SW-1:0] HALF    = SW'(16384);

  typedef logic [16:0] rom_t [SINE_TABLE_DEPTH + 1];

  // one table entry from a taylor series in Q2.30
  function automatic logic [16:0] sine_entry(int unsigned k);
    longint unsigned x, x2, term, r;
    longint          sum;
    x    = (PI_HALF_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + 64'd16384) >> 15;
    if (r > 64'(UNIT_Q15)) begin
      r = 64'(UNIT_Q15);
    end
    return r[16:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // stage 1: table read, pick the sample to be scaled and the pass-through
  logic                          v1_r;
  logic [16:0]                   g0_r, g1_r;
  logic signed [SAMPLE_BITS-1:0] other_r, base_l_r, base_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    g1_r     <= SINE_ROM[in_idx];
    g0_r     <= SINE_ROM[IDX_TOP - in_idx];
    other_r  <= in_pos ? in_left : in_right;
    base_l_r <= in_pos ? '0 : in_left;
    base_r_r <= in_pos ? in_right : '0;
  end

  // stage 2: gain multiplies
  logic                          v2_r;
  logic signed [PW-1:0]          prod_l_r, prod_r_r;
  logic signed [SAMPLE_BITS-1:0] base_l2_r, base_r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_l_r  <= PW'(other_r) * PW'($signed({1'b0, g0_r}));
    prod_r_r  <= PW'(other_r) * PW'($signed({1'b0, g1_r}));
    base_l2_r <= base_l_r;
    base_r2_r <= base_r_r;
  end

  // stage 3: add pass-through, round half up, saturate
  logic signed [SW-1:0] sum_l, sum_r, rnd_l, rnd_r;
  logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;

  always_comb begin
    sum_l = $signed({{3{base_l2_r[SAMPLE_BITS-1]}}, base_l2_r, 15'b0})
          + SW'(prod_l_r) + HALF;
    sum_r = $signed({{3{base_r2_r[SAMPLE_BITS-1]}}, base_r2_r, 15'b0})
          + SW'(prod_r_r) + HALF;
    rnd_l = sum_l >>> 15;
    rnd_r = sum_r >>> 15;
    priority if (rnd_l > SAT_HI) begin
      sat_l = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd_l < SAT_LO) begin
      sat_l = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_l = rnd_l[SAMPLE_BITS-1:0];
    end
    priority if (rnd_r > SAT_HI) begin
      sat_r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd_r < SAT_LO) begin
      sat_r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_r = rnd_r[SAMPLE_BITS-1:0];
    end
  end

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_left_r  <= sat_l;
    out_right_r <= sat_r;
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

// ----- sv/stereo_equal_power_panner.sv -----
// stereo equal-power panner: an accepted beat passes two front stages, the queue write
// and registered read and three back stages before its out_valid strobe; one beat per
// cycle sustained. busy rises only when the front stages and the queue together hold
// four beats, which a free-running back never lets happen. the sine table is a constant
// rom: synchronous reset clears valids, queue pointers, the fill count and the config
// registers only. depends on sepp_pkg, sepp_front, sepp_queue, sepp_back and the
// assertion header
`include "stereo_equal_power_panner_assert.svh"
module stereo_equal_power_panner #(
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic signed [15:0]            in_pan,
  // result beats
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sepp_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QW    = 2 * SAMPLE_BITS + IDX_W + 1;

  // config registers
  logic        flip_mode_r;
  logic [15:0] pan_scale_r;
  logic        cfg_wr;
  reg_idx_t    cfg_sel;
  cfg_t        cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_mode_r <= 1'b0;
      pan_scale_r <= PAN_SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FLIP_MODE: flip_mode_r <= pwdata[0];
        REG_PAN_SCALE: pan_scale_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_sel)
      REG_FLIP_MODE: prdata = {31'b0, flip_mode_r};
      REG_PAN_SCALE: prdata = {16'b0, pan_scale_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.flip_mode = flip_mode_r;
  assign cfg.pan_scale = pan_scale_r;

  // front
  logic                   accept;
  logic                   q_push;
  logic [SAMPLE_BITS-1:0] f_left, f_right;
  logic [IDX_W-1:0]       f_idx;
  logic                   f_pos;
  logic [1:0]             inflight;

  assign accept = start && !busy;

  sepp_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (accept),
    .in_left    (in_left),
    .in_right   (in_right),
    .in_pan     (in_pan),
    .push       (q_push),
    .push_left  (f_left),
    .push_right (f_right),
    .push_idx   (f_idx),
    .push_pos   (f_pos),
    .inflight   (inflight)
  );

  // queue
  queue_stat_t     q_stat;
  logic            q_rvalid;
  logic [QW-1:0]   q_rdata;

  sepp_queue #(
    .W (QW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  ({f_left, f_right, f_idx, f_pos}),
    .pop    (!q_stat.empty),
    .rvalid (q_rvalid),
    .rdata  (q_rdata),
    .stat   (q_stat)
  );

  // hold off the source when the queue could not take every beat in flight
  assign busy = (q_stat.count + QCNT_W'(inflight)) >= QCNT_W'(QUEUE_DEPTH);

  // back
  sepp_back #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_rvalid),
    .in_left   ($signed(q_rdata[QW-1 -: SAMPLE_BITS])),
    .in_right  ($signed(q_rdata[IDX_W + SAMPLE_BITS -: SAMPLE_BITS])),
    .in_idx    (q_rdata[IDX_W:1]),
    .in_pos    (q_rdata[0]),
    .out_valid (out_valid),
    .out_left  (out_left),
    .out_right (out_right)
  );

  // checks
  `SEPP_ASSERT_NEVER(a_queue_overflow, q_push && q_stat.full, "push into full queue")
  `SEPP_ASSERT_IMPLY(a_push_latency, q_push, $past(accept, 2), "push without accepted beat")
  `SEPP_ASSERT_IMPLY(a_out_latency, out_valid, $past(accept, 7), "result without accepted beat")

endmodule

// ----- tb/sv/stereo_equal_power_panner_checker.sv -----
// result checker for the stereo equal-power panner: predicts every output beat
// from the accepted input beats and the register writes it sees, then compares
// depends on sepp_pkg for the register indexes, the reset pan scale and pi/2 in Q2.30
module stereo_equal_power_panner_checker #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_right,
  input  logic signed [15:0] in_pan,
  input  logic               out_valid,
  input  logic signed [15:0] out_left,
  input  logic signed [15:0] out_right,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 pairs_pending
);
  import sepp_pkg::*;

  localparam longint ONE_Q15 = 32768;

  typedef struct {
    logic signed [15:0] src_left;
    logic signed [15:0] src_right;
    logic signed [15:0] src_pan;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } panned_pair_t;

  // quarter-wave sine in Q1.15, entry k is sin(pi/2 * k / depth)
  longint       sine_q15 [SINE_TABLE_DEPTH + 1];
  panned_pair_t panned_q [$];
  logic         flip_q;
  logic [15:0]  scale_q;
  int           beat_no;

  // build the table with the same truncating taylor series as the hardware rom
  initial begin
    longint unsigned x, x2, term, rnd;
    longint          sum;
    mismatch_count = 0;
    pairs_pending  = 0;
    beat_no        = 0;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (PI_HALF_Q30 * longint'(k) + longint'(SINE_TABLE_DEPTH / 2))
             / longint'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rnd = (longint'(sum) + 16384) >> 15;
      if (rnd > ONE_Q15) begin
        rnd = ONE_Q15;
      end
      sine_q15[k] = longint'(rnd);
    end
  end

  // round a Q2.30 product to Q1.15, ties upward, then clip to 16 bits
  function automatic logic signed [15:0] round_clip(input longint acc);
    longint v;
    v = (acc + 16384) >>> 15;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return 16'(v);
  endfunction

  // expected output pair for one input beat under the current registers
  function automatic panned_pair_t equal_power_pan(input logic signed [15:0] l,
                                                   input logic signed [15:0] r,
                                                   input logic signed [15:0] pn);
    panned_pair_t pair;
    longint       p, ph, idx, g0, g1, sl, sr;
    sl = longint'(l);
    sr = longint'(r);
    p  = (longint'(pn) * longint'({1'b0, scale_q})) / 16384;
    if (p > ONE_Q15) begin
      p = ONE_Q15;
    end else if (p < -ONE_Q15) begin
      p = -ONE_Q15;
    end
    if (flip_q) begin
      p = -p;
    end
    ph  = (p <= 0) ? p + ONE_Q15 : p;
    idx = (ph * SINE_TABLE_DEPTH + 16384) / ONE_Q15;
    if (idx > SINE_TABLE_DEPTH) begin
      idx = SINE_TABLE_DEPTH;
    end
    g1 = sine_q15[idx];
    g0 = sine_q15[SINE_TABLE_DEPTH - idx];
    pair.src_left  = l;
    pair.src_right = r;
    pair.src_pan   = pn;
    if (p > 0) begin
      pair.left  = round_clip(sl * g0);
      pair.right = round_clip(sr * ONE_Q15 + sl * g1);
    end else begin
      pair.left  = round_clip(sl * ONE_Q15 + sr * g0);
      pair.right = round_clip(sr * g1);
    end
    return pair;
  endfunction

  function automatic logic [31:0] reg_readback(input logic [2:0] addr);
    case (reg_idx_t'(addr[2]))
      REG_FLIP_MODE: return {31'd0, flip_q};
      default:       return {16'd0, scale_q};
    endcase
  endfunction

  task automatic flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // watch both channels and the register port at every rising edge
  always @(posedge clk) begin
    panned_pair_t want;
    if (!rst_n) begin
      flip_q  = 1'b0;
      scale_q = PAN_SCALE_RESET;
    end else begin
      // output beat against the oldest prediction
      if (out_valid) begin
        if (panned_q.size() == 0) begin
          flag($sformatf("output beat l=%0d r=%0d with no input beat pending",
                         out_left, out_right));
        end else begin
          want = panned_q.pop_front();
          if (out_left !== want.left || out_right !== want.right) begin
            flag($sformatf({"beat %0d (in l=%0d r=%0d pan=%0d): expected l=%0d r=%0d,",
                            " got l=%0d r=%0d"}, beat_no, want.src_left,
                           want.src_right, want.src_pan, want.left, want.right,
                           out_left, out_right));
          end
          beat_no++;
        end
      end
      // accepted input beat
      if (start && !busy) begin
        panned_q.push_back(equal_power_pan(in_left, in_right, in_pan));
      end
      // register access phase
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[2]))
            REG_FLIP_MODE: flip_q  = pwdata[0];
            REG_PAN_SCALE: scale_q = pwdata[15:0];
          endcase
        end else if (prdata !== reg_readback(paddr)) begin
          flag($sformatf("register read at %0d: expected %0h, got %0h",
                         paddr, reg_readback(paddr), prdata));
        end
      end
    end
    pairs_pending = panned_q.size();
  end

endmodule

// ----- tb/sv/stereo_equal_power_panner_tb.sv -----
// top of the stereo equal-power panner bench: clock, reset, input and register
// stimulus, watchdog and verdict; checking lives in the checker module
// depends on sepp_pkg, stereo_equal_power_panner and its checker
module stereo_equal_power_panner_tb;
  import sepp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_left;
  logic signed [15:0] in_right;
  logic signed [15:0] in_pan;
  logic               out_valid;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatch_count;
  int                 pairs_pending;
  int                 quiet_cycles;

  stereo_equal_power_panner uut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_left(in_left), .in_right(in_right), .in_pan(in_pan),
    .out_valid(out_valid), .out_left(out_left), .out_right(out_right),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stereo_equal_power_panner_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_left(in_left), .in_right(in_right), .in_pan(in_pan),
    .out_valid(out_valid), .out_left(out_left), .out_right(out_right),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatch_count(mismatch_count), .pairs_pending(pairs_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog on cycles where no beat or register access goes through
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sample values weighted toward the extremes
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // pan values weighted toward the ends, the center and the half points
  function automatic logic signed [15:0] pick_pan();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'($urandom_range(0, 8)) - 16'sd4;
      4:       return 16'sd16384 + 16'($urandom_range(0, 64)) - 16'sd32;
      5:       return -16'sd16384 + 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input beat, start held until the block takes it
  task automatic send_beat(input logic signed [15:0] l, input logic signed [15:0] r,
                           input logic signed [15:0] pn);
    @(negedge clk);
    start    <= 1'b1;
    in_left  <= l;
    in_right <= r;
    in_pan   <= pn;
    do @(posedge clk); while (busy);
  endtask

  // idle the sender with noise on the data ports; n sets the length of the gap
  task automatic idle_gap(input int n);
    @(negedge clk);
    start    <= 1'b0;
    in_left  <= 16'($urandom);
    in_right <= 16'($urandom);
    in_pan   <= 16'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // hold the sender until every predicted beat has come out
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pairs_pending != 0) @(negedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new register setting with junk in the unused upper bits, then read back
  task automatic reconfigure(input logic flip, input logic [15:0] scale);
    logic [31:0] junk;
    drain_results();
    junk    = $urandom;
    junk[0] = flip;
    apb_access(REG_FLIP_MODE, 1'b1, junk);
    junk       = $urandom;
    junk[15:0] = scale;
    apb_access(REG_PAN_SCALE, 1'b1, junk);
    apb_access(REG_FLIP_MODE, 1'b0, 32'd0);
    apb_access(REG_PAN_SCALE, 1'b0, 32'd0);
  endtask

  // random beats, with idle bursts where allowed
  task automatic run_beats(input int n_beats, input bit idle_ok);
    for (int i = 0; i < n_beats; i++) begin
      send_beat(pick_sample(), pick_sample(), pick_pan());
      if (idle_ok && $urandom_range(0, 4) == 0) begin
        idle_gap($urandom_range(1, 18));
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_left  = '0;
    in_right = '0;
    in_pan   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of both registers
    apb_access(REG_FLIP_MODE, 1'b0, 32'd0);
    apb_access(REG_PAN_SCALE, 1'b0, 32'd0);

    // field extremes at unity scale, no flip
    send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_beat(16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(16'sh7fff, 16'sh8000, 16'sh0000);
    send_beat(16'sh8000, 16'sh7fff, 16'sh0000);
    send_beat(16'sh0000, 16'sh0000, 16'sh0000);
    send_beat(16'sh7fff, 16'sh7fff, 16'sh8000);
    send_beat(16'sh8000, 16'sh8000, 16'sh7fff);
    send_beat(16'sd12345, -16'sd23456, 16'sd1);
    send_beat(16'sd12345, -16'sd23456, -16'sd1);
    send_beat(16'sh7fff, 16'sh7fff, 16'sd16384);
    send_beat(16'sh8000, 16'sh7fff, -16'sd16384);

    // flipped: zero pan stays on the left branch, full left becomes full right
    reconfigure(1'b1, 16'd16384);
    send_beat(16'sd1234, -16'sd4321, 16'sh0000);
    send_beat(16'sh7fff, 16'sh7fff, 16'sh0000);
    send_beat(16'sh7fff, 16'sh7fff, 16'sh8000);
    send_beat(16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(16'sd20000, -16'sd5000, 16'sh8000);
    send_beat(16'sd20000, -16'sd5000, 16'sh7fff);

    // double scale clamps the pan at both ends
    reconfigure(1'b0, 16'd32768);
    send_beat(16'sd30000, 16'sd30000, 16'sh7fff);
    send_beat(16'sd30000, -16'sd30000, 16'sh8000);
    send_beat(-16'sd1000, 16'sd7000, 16'sd20000);
    send_beat(-16'sd1000, 16'sd7000, -16'sd20000);
    send_beat(16'sd1000, 16'sd7000, 16'sd16384);

    // random phases over extreme and random settings
    reconfigure(1'b0, 16'd16384);
    run_beats(50, 1'b1);
    drain_results();
    run_beats(50, 1'b1);
    reconfigure(1'b1, 16'd0);
    run_beats(90, 1'b1);
    reconfigure(1'b0, 16'd0);
    run_beats(90, 1'b1);
    reconfigure(1'b1, 16'd32768);
    run_beats(100, 1'b1);
    reconfigure(1'b0, 16'd32768);
    run_beats(100, 1'b1);
    for (int ph = 0; ph < 3; ph++) begin
      reconfigure(1'($urandom), 16'($urandom_range(0, 32768)));
      run_beats(70, 1'b1);
    end
    // closing stretch back to back
    reconfigure(1'b1, 16'($urandom_range(0, 32768)));
    run_beats(120, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pairs_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
